// ----- src/padsr_pkg.sv -----
// Shared types and constants of the polyphonic ADSR envelope table.
package padsr_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int NUM_KEYS_DEF = 128;

	localparam int CNT_W = 22;
	localparam int LVL_W = 16;
	localparam int VEL_W = 8;
	localparam int TIME_W = 20;
	localparam int QUO_W = 16;
	localparam int PROD_W = TIME_W + QUO_W;
	localparam int VOICE_W = CNT_W + LVL_W + VEL_W + 1;

	localparam logic [LVL_W-1:0] LEVEL_ONE = 16'd32768;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_NOTE_ON  = 2'd1,
		REQ_NOTE_OFF = 2'd2,
		REQ_PANIC    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STG_IDLE    = 3'd0,
		STG_ATTACK  = 3'd1,
		STG_DECAY   = 3'd2,
		STG_SUSTAIN = 3'd3,
		STG_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [2:0] {
		REG_ATTACK_TIME   = 3'd0,
		REG_DECAY_TIME    = 3'd1,
		REG_RELEASE_TIME  = 3'd2,
		REG_ATTACK_LEVEL  = 3'd3,
		REG_SUSTAIN_LEVEL = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_PANIC,
		ST_ENV,
		ST_MUL,
		ST_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic [LVL_W-1:0]        lvl;
		logic signed [VEL_W-1:0] vel;
		logic                    snd;
	} voice_t;

endpackage

// ----- src/padsr_ram.sv -----
// Generic single-port RAM with registered read.
module padsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- src/polyphonic_adsr_envelope.sv -----
// Top level of the polyphonic ADSR envelope table.
//
// Requests enter on the valid/stall input channel: a sample tick, note on,
// note off or channel panic addressed to one key (channel, note). Every
// request yields exactly one result on the valid/stall output channel:
// the key's level, stage, velocity magnitude, end-of-voice flag and the
// channel's count of sounding keys.
// Per-key state lives in one RAM entry that is read, updated and written
// back; one request is in flight at a time, so no entry is ever accessed
// by two requests at once.
// Note on/off, ticks of a silent key and out-of-range requests go straight
// from lookup to the result; a tick takes its level straight from a register
// or interpolates it with the bit-serial divider, and a retrigger or note-off
// cross-fade runs the envelope twice. A panic sweeps the channel's NUM_KEYS
// entries.
// After reset the block clears all NUM_CHANNELS*NUM_KEYS entries, one per
// cycle, holding in_stall high; the configuration port works meanwhile.
// A stalled result holds the output register; the block then finishes the
// next request's work and waits to load its result.
module polyphonic_adsr_envelope #(
	parameter int NUM_CHANNELS = padsr_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_KEYS = padsr_pkg::NUM_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  channel,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] env_level,
	output logic [6:0]  key_velocity,
	output logic [2:0]  stage,
	output logic        voice_ended,
	output logic [7:0]  active_keys
);

	localparam int DEPTH = NUM_CHANNELS * NUM_KEYS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W = padsr_pkg::CNT_W;
	localparam int LVL_W = padsr_pkg::LVL_W;
	localparam int TIME_W = padsr_pkg::TIME_W;
	localparam int QUO_W = padsr_pkg::QUO_W;
	localparam int PROD_W = padsr_pkg::PROD_W;
	localparam int DCNT_W = $clog2(QUO_W);

	// configuration registers
	logic [TIME_W-1:0] attack_time_q, decay_time_q, release_time_q;
	logic [LVL_W-1:0]  attack_level_q, sustain_level_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_time_q   <= 20'd240;
			decay_time_q    <= 20'd38400;
			release_time_q  <= 20'd4800;
			attack_level_q  <= padsr_pkg::LEVEL_ONE;
			sustain_level_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				padsr_pkg::REG_ATTACK_TIME:   attack_time_q   <= pwdata[TIME_W-1:0];
				padsr_pkg::REG_DECAY_TIME:    decay_time_q    <= pwdata[TIME_W-1:0];
				padsr_pkg::REG_RELEASE_TIME:  release_time_q  <= pwdata[TIME_W-1:0];
				padsr_pkg::REG_ATTACK_LEVEL:  attack_level_q  <= pwdata[LVL_W-1:0];
				padsr_pkg::REG_SUSTAIN_LEVEL: sustain_level_q <= pwdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			padsr_pkg::REG_ATTACK_TIME:   prdata = 32'(attack_time_q);
			padsr_pkg::REG_DECAY_TIME:    prdata = 32'(decay_time_q);
			padsr_pkg::REG_RELEASE_TIME:  prdata = 32'(release_time_q);
			padsr_pkg::REG_ATTACK_LEVEL:  prdata = 32'(attack_level_q);
			padsr_pkg::REG_SUSTAIN_LEVEL: prdata = 32'(sustain_level_q);
			default:                      prdata = '0;
		endcase
	end

	// effective times (zero counts as one) and levels (clamped to 1.0)
	logic [TIME_W-1:0] a_eff, d_eff, r_eff;
	logic [LVL_W-1:0]  al_eff, sl_eff;
	logic [CNT_W-1:0]  e1, e2, e3;

	assign a_eff  = (attack_time_q == '0) ? TIME_W'(1) : attack_time_q;
	assign d_eff  = (decay_time_q == '0) ? TIME_W'(1) : decay_time_q;
	assign r_eff  = (release_time_q == '0) ? TIME_W'(1) : release_time_q;
	assign al_eff = (attack_level_q > padsr_pkg::LEVEL_ONE) ? padsr_pkg::LEVEL_ONE
		: attack_level_q;
	assign sl_eff = (sustain_level_q > padsr_pkg::LEVEL_ONE) ? padsr_pkg::LEVEL_ONE
		: sustain_level_q;
	assign e1 = CNT_W'(a_eff);
	assign e2 = e1 + CNT_W'(d_eff);
	assign e3 = e2 + CNT_W'(r_eff);

	// control and working registers
	padsr_pkg::state_t state_q, state_d;
	padsr_pkg::req_t   req_q;
	padsr_pkg::voice_t w_q, rd_data, wr_data;
	padsr_pkg::stage_t stg_q, res_stg_q, seg_stage;

	logic [3:0]        ch_q;
	logic [6:0]        in_vel_q;
	logic [ADDR_W-1:0] addr_q, base_q, in_base, in_addr, ram_addr;
	logic [ADDR_W-1:0] sw_q;
	logic [ADDR_W:0]   left_q;
	logic              skip_q, in_skip;
	logic              pre_q, retrig_q;
	logic              direct_q, up_q;
	logic [LVL_W-1:0]  dval_q, diff_q;
	logic [TIME_W-1:0] p_q, t_q;
	logic [TIME_W-1:0] rem_q;
	logic [QUO_W-1:0]  prod_lo_q, quo_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [LVL_W-1:0]  res_lvl_q;
	logic              res_end_q;
	logic [7:0]        counts_q [NUM_CHANNELS];

	logic              accept, out_free, ram_we;
	logic [7:0]        ch_count;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != padsr_pkg::ST_IDLE);
	assign ch_count = counts_q[ch_q[CH_W-1:0]];

	assign in_skip = (32'(channel) >= NUM_CHANNELS) || (32'(note) >= NUM_KEYS);
	assign in_base = ADDR_W'(32'(channel) * NUM_KEYS);
	assign in_addr = in_base + ADDR_W'(note);

	// one envelope sample: pick the segment from the counter
	logic [CNT_W-1:0] c_cur, seg_p, seg_newcnt;
	logic [TIME_W-1:0] seg_t;
	logic [LVL_W-1:0] seg_tgt, seg_dval, seg_diff;
	logic             seg_lerp, seg_exact;

	always_comb begin
		c_cur      = w_q.cnt;
		seg_stage  = padsr_pkg::STG_IDLE;
		seg_p      = '0;
		seg_t      = TIME_W'(1);
		seg_tgt    = '0;
		seg_newcnt = '0;
		seg_lerp   = 1'b0;
		if (c_cur < e1) begin
			seg_stage  = padsr_pkg::STG_ATTACK;
			seg_p      = c_cur + CNT_W'(1);
			seg_newcnt = c_cur + CNT_W'(1);
			seg_t      = a_eff;
			seg_tgt    = al_eff;
			seg_lerp   = 1'b1;
		end else if (c_cur < e2) begin
			seg_stage  = padsr_pkg::STG_DECAY;
			seg_p      = c_cur + CNT_W'(1) - e1;
			seg_newcnt = c_cur + CNT_W'(1);
			seg_t      = d_eff;
			seg_tgt    = sl_eff;
			seg_lerp   = 1'b1;
		end else if (c_cur == e2) begin
			seg_stage  = padsr_pkg::STG_SUSTAIN;
			seg_newcnt = c_cur;
			seg_tgt    = sl_eff;
		end else if (c_cur < e3) begin
			seg_stage  = padsr_pkg::STG_RELEASE;
			seg_p      = c_cur + CNT_W'(1) - e2;
			seg_newcnt = c_cur + CNT_W'(1);
			seg_t      = r_eff;
			seg_tgt    = '0;
			seg_lerp   = 1'b1;
		end
		seg_exact = seg_lerp && (seg_p == CNT_W'(seg_t));
		seg_dval  = seg_tgt;
		seg_diff  = (seg_tgt >= w_q.lvl) ? (seg_tgt - w_q.lvl) : (w_q.lvl - seg_tgt);
	end

	// bit-serial divider step and sample value
	logic [TIME_W:0]   trial;
	logic              trial_ge;
	logic [PROD_W-1:0] prod;
	logic [LVL_W-1:0]  smp_val;

	assign trial    = {rem_q, prod_lo_q[QUO_W-1]};
	assign trial_ge = (trial >= {1'b0, t_q});
	assign prod     = PROD_W'(p_q) * PROD_W'(diff_q);
	assign smp_val  = direct_q ? dval_q : (up_q ? (w_q.lvl + quo_q) : (w_q.lvl - quo_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			padsr_pkg::ST_CLEAR: begin
				if (left_q == (ADDR_W+1)'(1)) state_d = padsr_pkg::ST_IDLE;
			end
			padsr_pkg::ST_IDLE: begin
				if (accept) state_d = padsr_pkg::ST_LOOK;
			end
			padsr_pkg::ST_LOOK: begin
				if (skip_q) begin
					state_d = padsr_pkg::ST_DONE;
				end else begin
					case (req_q)
						padsr_pkg::REQ_PANIC: state_d = padsr_pkg::ST_PANIC;
						padsr_pkg::REQ_TICK: begin
							if (rd_data.vel == 8'sd0 || (!rd_data.snd && rd_data.vel < 8'sd0))
								state_d = padsr_pkg::ST_DONE;
							else
								state_d = padsr_pkg::ST_ENV;
						end
						default: state_d = padsr_pkg::ST_DONE;
					endcase
				end
			end
			padsr_pkg::ST_PANIC: begin
				if (left_q == (ADDR_W+1)'(1)) state_d = padsr_pkg::ST_DONE;
			end
			padsr_pkg::ST_ENV: begin
				state_d = (seg_lerp && !seg_exact) ? padsr_pkg::ST_MUL : padsr_pkg::ST_APPLY;
			end
			padsr_pkg::ST_MUL: state_d = padsr_pkg::ST_DIV;
			padsr_pkg::ST_DIV: begin
				if (dcnt_q == DCNT_W'(QUO_W - 1)) state_d = padsr_pkg::ST_APPLY;
			end
			padsr_pkg::ST_APPLY: begin
				state_d = pre_q ? padsr_pkg::ST_ENV : padsr_pkg::ST_DONE;
			end
			padsr_pkg::ST_DONE: begin
				if (out_free) state_d = padsr_pkg::ST_IDLE;
			end
			default: state_d = padsr_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= padsr_pkg::ST_CLEAR;
		else         state_q <= state_d;
	end

	// voice RAM: sweep during clear and panic, write back at completion
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = addr_q;
		wr_data  = w_q;
		case (state_q)
			padsr_pkg::ST_IDLE: ram_addr = in_addr;
			padsr_pkg::ST_CLEAR, padsr_pkg::ST_PANIC: begin
				ram_we   = 1'b1;
				ram_addr = sw_q;
				wr_data  = '0;
			end
			padsr_pkg::ST_DONE: ram_we = out_free && !skip_q;
			default: ;
		endcase
	end

	padsr_ram #(
		.WIDTH(padsr_pkg::VOICE_W),
		.DEPTH(DEPTH),
		.ADDR_W(ADDR_W)
	) u_voice_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(wr_data),
		.rdata(rd_data)
	);

	// sweep counters (reset clear pass and channel panic)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= '0;
			left_q <= (ADDR_W+1)'(DEPTH);
		end else if (state_q == padsr_pkg::ST_CLEAR || state_q == padsr_pkg::ST_PANIC) begin
			sw_q   <= sw_q + ADDR_W'(1);
			left_q <= left_q - (ADDR_W+1)'(1);
		end else if (state_q == padsr_pkg::ST_LOOK) begin
			sw_q   <= base_q;
			left_q <= (ADDR_W+1)'(NUM_KEYS);
		end
	end

	// per-channel sounding key counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) counts_q[i] <= '0;
		end else if (state_q == padsr_pkg::ST_LOOK && !skip_q) begin
			if (req_q == padsr_pkg::REQ_PANIC)
				counts_q[ch_q[CH_W-1:0]] <= '0;
			else if (req_q == padsr_pkg::REQ_TICK && !rd_data.snd && rd_data.vel > 8'sd0)
				counts_q[ch_q[CH_W-1:0]] <= ch_count + 8'd1;
		end else if (state_q == padsr_pkg::ST_APPLY && !pre_q && w_q.cnt == '0) begin
			counts_q[ch_q[CH_W-1:0]] <= ch_count - 8'd1;
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			padsr_pkg::ST_IDLE: begin
				req_q    <= padsr_pkg::req_t'(req_type);
				ch_q     <= channel;
				in_vel_q <= velocity;
				base_q   <= in_base;
				addr_q   <= in_addr;
				skip_q   <= in_skip;
			end
			padsr_pkg::ST_LOOK: begin
				w_q       <= rd_data;
				pre_q     <= 1'b0;
				retrig_q  <= 1'b0;
				res_lvl_q <= '0;
				res_stg_q <= padsr_pkg::STG_IDLE;
				res_end_q <= 1'b0;
				case (req_q)
					padsr_pkg::REQ_NOTE_ON: begin
						if (rd_data.vel <= 8'sd0) w_q.vel <= {1'b0, in_vel_q};
					end
					padsr_pkg::REQ_NOTE_OFF: begin
						if (rd_data.vel > 8'sd0) w_q.vel <= -rd_data.vel;
					end
					padsr_pkg::REQ_PANIC: w_q <= '0;
					default: begin
						if (rd_data.vel > 8'sd0) begin
							if (!rd_data.snd) begin
								// new note: start from silence
								w_q.lvl <= '0;
								w_q.cnt <= '0;
								w_q.snd <= 1'b1;
							end else if (rd_data.cnt > e2) begin
								// retrigger in release: cross-fade into attack
								pre_q    <= 1'b1;
								retrig_q <= 1'b1;
							end
						end else if (rd_data.vel < 8'sd0) begin
							if (rd_data.snd) begin
								if (rd_data.cnt < e2) begin
									pre_q <= 1'b1;
								end else if (rd_data.cnt == e2) begin
									w_q.cnt <= e2 + CNT_W'(1);
								end
							end else begin
								// cancel: off arrived before the voice started
								w_q.vel <= '0;
								w_q.cnt <= '0;
							end
						end
					end
				endcase
			end
			padsr_pkg::ST_ENV: begin
				w_q.cnt  <= seg_newcnt;
				stg_q    <= seg_stage;
				direct_q <= !seg_lerp || seg_exact;
				dval_q   <= seg_dval;
				if (seg_exact) w_q.lvl <= seg_tgt;
				up_q     <= (seg_tgt >= w_q.lvl);
				diff_q   <= seg_diff;
				p_q      <= seg_p[TIME_W-1:0];
				t_q      <= seg_t;
			end
			padsr_pkg::ST_MUL: begin
				rem_q     <= prod[PROD_W-1:QUO_W];
				prod_lo_q <= prod[QUO_W-1:0];
				quo_q     <= '0;
				dcnt_q    <= '0;
			end
			padsr_pkg::ST_DIV: begin
				rem_q     <= trial_ge ? TIME_W'(trial - {1'b0, t_q}) : trial[TIME_W-1:0];
				prod_lo_q <= {prod_lo_q[QUO_W-2:0], 1'b0};
				quo_q     <= {quo_q[QUO_W-2:0], trial_ge};
				dcnt_q    <= dcnt_q + DCNT_W'(1);
			end
			padsr_pkg::ST_APPLY: begin
				if (pre_q) begin
					// cross-fade: start the new segment from the current level
					w_q.lvl <= smp_val;
					w_q.cnt <= retrig_q ? '0 : (e2 + CNT_W'(1));
					pre_q   <= 1'b0;
				end else if (w_q.cnt == '0) begin
					// release done: drop the voice
					w_q.vel   <= '0;
					w_q.lvl   <= '0;
					w_q.snd   <= 1'b0;
					res_end_q <= 1'b1;
				end else begin
					res_lvl_q <= smp_val;
					res_stg_q <= stg_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	logic [6:0] vel_mag;
	assign vel_mag = w_q.vel[7] ? 7'(-w_q.vel) : w_q.vel[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == padsr_pkg::ST_DONE && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == padsr_pkg::ST_DONE && out_free) begin
			env_level    <= skip_q ? '0 : res_lvl_q;
			key_velocity <= skip_q ? '0 : vel_mag;
			stage        <= skip_q ? padsr_pkg::STG_IDLE : res_stg_q;
			voice_ended  <= skip_q ? 1'b0 : res_end_q;
			active_keys  <= skip_q ? '0 : ch_count;
		end
	end

	// checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted but block did not go busy");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == padsr_pkg::ST_APPLY && !direct_q) |-> (quo_q <= diff_q))
		else $error("interpolation step larger than level span");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == padsr_pkg::ST_DONE && !skip_q) |-> (32'(ch_count) <= NUM_KEYS))
		else $error("channel key count out of range");

	a_end_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && voice_ended) |-> (env_level == '0 && stage == padsr_pkg::STG_IDLE))
		else $error("ended voice reports a level");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == padsr_pkg::ST_MUL) |=> (state_q == padsr_pkg::ST_DIV && dcnt_q == '0))
		else $error("divider did not start cleanly");

endmodule

// ----- tb/padsr_checker.sv -----
// Scoreboard for the polyphonic ADSR envelope table: predicts every result and compares.
`timescale 1ns / 100ps
module padsr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  channel,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] env_level,
	input  logic [6:0]  key_velocity,
	input  logic [2:0]  stage,
	input  logic        voice_ended,
	input  logic [7:0]  active_keys,
	output int          fail_count,
	output int          pending_requests
);

	localparam int NCH = padsr_pkg::NUM_CHANNELS_DEF;
	localparam int NKEY = padsr_pkg::NUM_KEYS_DEF;
	localparam int VOICES = NCH * NKEY;
	localparam int TIME_W = padsr_pkg::TIME_W;
	localparam int LVL_W = padsr_pkg::LVL_W;
	localparam int CNT_W = padsr_pkg::CNT_W;
	localparam int VEL_W = padsr_pkg::VEL_W;

	typedef struct {
		logic [15:0] lvl;
		logic [6:0]  vel;
		logic [2:0]  stg;
		logic        ended;
		logic [7:0]  keys;
	} env_result_t;

	env_result_t expected_results[$];

	logic [TIME_W-1:0] atk_time, dec_time, rel_time;
	logic [LVL_W-1:0]  atk_lvl, sus_lvl;

	logic [CNT_W-1:0]        sample_cnt[VOICES];
	logic [LVL_W-1:0]        from_lvl[VOICES];
	logic signed [VEL_W-1:0] held_vel[VOICES];
	bit                      sounding[VOICES];
	logic [7:0]              key_count[NCH];

	assign pending_requests = expected_results.size();

	function automatic int unsigned eff_time(logic [TIME_W-1:0] r);
		return (r == 0) ? 1 : r;
	endfunction

	function automatic int unsigned eff_lvl(logic [LVL_W-1:0] r);
		return (r > padsr_pkg::LEVEL_ONE) ? padsr_pkg::LEVEL_ONE : r;
	endfunction

	function automatic int unsigned interpolate(int unsigned from, int unsigned to,
			int unsigned p, int unsigned t);
		longint unsigned q;
		if (to >= from) begin
			q = (longint'(p) * longint'(to - from)) / t;
			return from + int'(q);
		end
		q = (longint'(p) * longint'(from - to)) / t;
		return from - int'(q);
	endfunction

	// Produce one envelope sample for voice k and advance its counter.
	task automatic advance_envelope(input int k, output int unsigned lvl,
			output padsr_pkg::stage_t stg);
		int unsigned a, d, r, al, sl, e1, e2, e3, c, p;
		a = eff_time(atk_time);
		d = eff_time(dec_time);
		r = eff_time(rel_time);
		al = eff_lvl(atk_lvl);
		sl = eff_lvl(sus_lvl);
		e1 = a;
		e2 = a + d;
		e3 = a + d + r;
		c = sample_cnt[k];
		if (c < e1) begin
			stg = padsr_pkg::STG_ATTACK;
			p = c + 1;
			sample_cnt[k] = CNT_W'(p);
			if (p == a) begin
				from_lvl[k] = LVL_W'(al);
				lvl = al;
			end else
				lvl = interpolate(from_lvl[k], al, p, a);
		end else if (c < e2) begin
			stg = padsr_pkg::STG_DECAY;
			sample_cnt[k] = CNT_W'(c + 1);
			p = c + 1 - e1;
			if (p == d) begin
				from_lvl[k] = LVL_W'(sl);
				lvl = sl;
			end else
				lvl = interpolate(from_lvl[k], sl, p, d);
		end else if (c == e2) begin
			stg = padsr_pkg::STG_SUSTAIN;
			lvl = sl;
		end else if (c < e3) begin
			stg = padsr_pkg::STG_RELEASE;
			sample_cnt[k] = CNT_W'(c + 1);
			p = c + 1 - e2;
			if (p == r) begin
				from_lvl[k] = '0;
				lvl = 0;
			end else
				lvl = interpolate(from_lvl[k], 0, p, r);
		end else begin
			stg = padsr_pkg::STG_IDLE;
			sample_cnt[k] = '0;
			lvl = 0;
		end
	endtask

	// Run the key lifecycle for one tick, then one envelope sample.
	task automatic tick_voice(input int k, input int ch, inout env_result_t res);
		logic signed [VEL_W-1:0] v;
		int unsigned e2, lvl;
		padsr_pkg::stage_t stg;
		v = held_vel[k];
		if (v == 0)
			return;
		e2 = eff_time(atk_time) + eff_time(dec_time);
		if (!sounding[k] && v > 0) begin
			from_lvl[k] = '0;
			sample_cnt[k] = '0;
			sounding[k] = 1'b1;
			key_count[ch] = key_count[ch] + 8'd1;
		end else if (sounding[k] && v > 0) begin
			// retrigger from release: cross-fade into a new attack
			if (sample_cnt[k] > e2) begin
				advance_envelope(k, lvl, stg);
				from_lvl[k] = LVL_W'(lvl);
				sample_cnt[k] = '0;
			end
		end else if (sounding[k]) begin
			if (sample_cnt[k] <= e2) begin
				if (sample_cnt[k] != e2) begin
					advance_envelope(k, lvl, stg);
					from_lvl[k] = LVL_W'(lvl);
				end
				sample_cnt[k] = CNT_W'(e2 + 1);
			end
		end else begin
			// on and off both arrived before the first tick: cancel
			held_vel[k] = '0;
			sample_cnt[k] = '0;
			return;
		end
		advance_envelope(k, lvl, stg);
		if (sample_cnt[k] == 0) begin
			held_vel[k] = '0;
			from_lvl[k] = '0;
			sounding[k] = 1'b0;
			key_count[ch] = key_count[ch] - 8'd1;
			res.ended = 1'b1;
			return;
		end
		res.lvl = 16'(lvl);
		res.stg = stg;
	endtask

	task automatic predict_request(input padsr_pkg::req_t kind, input int ch, input int nt,
			input logic [6:0] vel);
		env_result_t res;
		int k;
		logic signed [VEL_W-1:0] h;
		res = '{lvl: 0, vel: 0, stg: padsr_pkg::STG_IDLE, ended: 0, keys: 0};
		k = ch * NKEY + nt;
		case (kind)
			padsr_pkg::REQ_TICK: tick_voice(k, ch, res);
			padsr_pkg::REQ_NOTE_ON: if (held_vel[k] <= 0) held_vel[k] = {1'b0, vel};
			padsr_pkg::REQ_NOTE_OFF: if (held_vel[k] > 0) held_vel[k] = -held_vel[k];
			default: begin
				for (int i = 0; i < NKEY; i++) begin
					sample_cnt[ch * NKEY + i] = '0;
					from_lvl[ch * NKEY + i] = '0;
					held_vel[ch * NKEY + i] = '0;
					sounding[ch * NKEY + i] = 1'b0;
				end
				key_count[ch] = '0;
			end
		endcase
		h = held_vel[k];
		res.vel = (h < 0) ? 7'(-h) : 7'(h);
		res.keys = key_count[ch];
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		env_result_t want;
		if (!arst_n) begin
			atk_time = TIME_W'(240);
			dec_time = TIME_W'(38400);
			rel_time = TIME_W'(4800);
			atk_lvl = padsr_pkg::LEVEL_ONE;
			sus_lvl = '0;
			for (int i = 0; i < VOICES; i++) begin
				sample_cnt[i] = '0;
				from_lvl[i] = '0;
				held_vel[i] = '0;
				sounding[i] = 1'b0;
			end
			for (int i = 0; i < NCH; i++)
				key_count[i] = '0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (padsr_pkg::reg_idx_t'(paddr[4:2]))
					padsr_pkg::REG_ATTACK_TIME:   atk_time = pwdata[TIME_W-1:0];
					padsr_pkg::REG_DECAY_TIME:    dec_time = pwdata[TIME_W-1:0];
					padsr_pkg::REG_RELEASE_TIME:  rel_time = pwdata[TIME_W-1:0];
					padsr_pkg::REG_ATTACK_LEVEL:  atk_lvl = pwdata[LVL_W-1:0];
					padsr_pkg::REG_SUSTAIN_LEVEL: sus_lvl = pwdata[LVL_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_request(padsr_pkg::req_t'(req_type), channel, note, velocity);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request waiting", $realtime);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (env_level !== want.lvl) report_mismatch("env_level", env_level, want.lvl);
					if (key_velocity !== want.vel)
						report_mismatch("key_velocity", key_velocity, want.vel);
					if (stage !== want.stg) report_mismatch("stage", stage, want.stg);
					if (voice_ended !== want.ended)
						report_mismatch("voice_ended", voice_ended, want.ended);
					if (active_keys !== want.keys)
						report_mismatch("active_keys", active_keys, want.keys);
				end
			end
		end
	end

endmodule

// ----- tb/polyphonic_adsr_envelope_tb.sv -----
// Top of the envelope table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module polyphonic_adsr_envelope_tb;

	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 900;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [1:0]  req_type;
	logic [3:0]  channel;
	logic [6:0]  note, velocity;
	logic        out_valid, out_stall;
	logic [15:0] env_level;
	logic [6:0]  key_velocity;
	logic [2:0]  stage;
	logic        voice_ended;
	logic [7:0]  active_keys;

	int fail_count;
	int pending_requests;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	int sent_items;

	polyphonic_adsr_envelope DUT (.*);

	padsr_checker scoreboard (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Stall the output channel at random, at the rate the current phase asks.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Abort when no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("polyphonic_adsr_envelope_tb failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Issue one request and hold it until the block takes it. Called at a falling edge.
	task automatic send_request(input padsr_pkg::req_t kind, input int ch, input int nt,
			input int vel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		req_type <= kind;
		channel <= 4'(ch);
		note <= 7'(nt);
		velocity <= 7'(vel);
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent_items++;
	endtask

	// Lower the request, let every result drain, then give the datapath time to settle.
	task automatic drain_results();
		in_valid <= 0;
		while (pending_requests != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(input padsr_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
	endtask

	task automatic load_envelope(input int a, input int d, input int r, input int al,
			input int sl);
		drain_results();
		write_reg(padsr_pkg::REG_ATTACK_TIME, a);
		write_reg(padsr_pkg::REG_DECAY_TIME, d);
		write_reg(padsr_pkg::REG_RELEASE_TIME, r);
		write_reg(padsr_pkg::REG_ATTACK_LEVEL, al);
		write_reg(padsr_pkg::REG_SUSTAIN_LEVEL, sl);
	endtask

	// Mostly well-formed note traffic on a handful of keys, with some full-range noise.
	task automatic random_request();
		int pick, ch, nt, vel;
		pick = $urandom_range(99);
		ch = $urandom_range(1) ? 15 : 3;
		nt = $urandom_range(3) + ($urandom_range(1) ? 124 : 0);
		vel = ($urandom_range(19) == 0) ? 0 : $urandom_range(127, 1);
		if (pick < 55)
			send_request(padsr_pkg::REQ_TICK, ch, nt, $urandom_range(127));
		else if (pick < 72)
			send_request(padsr_pkg::REQ_NOTE_ON, ch, nt, vel);
		else if (pick < 90)
			send_request(padsr_pkg::REQ_NOTE_OFF, ch, nt, $urandom_range(127));
		else if (pick < 92)
			send_request(padsr_pkg::REQ_PANIC, ch, nt, $urandom_range(127));
		else
			send_request(padsr_pkg::req_t'($urandom_range(3)), $urandom_range(15),
				$urandom_range(127), $urandom_range(127));
	endtask

	initial begin
		arst_n <= 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= 0;
		pwdata <= 0;
		in_valid <= 0;
		req_type <= padsr_pkg::REQ_TICK;
		channel <= 0;
		note <= 0;
		velocity <= 0;
		out_stall <= 0;
		quiet_cycles <= 0;
		sent_items = 0;
		send_idle_pct = 10;
		recv_stall_pct = 61;
		repeat (7) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: short segments so whole notes fit in a few ticks.
		load_envelope(2, 3, 2, 32768, 16000);
		send_request(padsr_pkg::REQ_NOTE_ON, 0, 0, 0);
		send_request(padsr_pkg::REQ_TICK, 0, 0, 0);
		send_request(padsr_pkg::REQ_NOTE_ON, 15, 127, 127);
		repeat (7) send_request(padsr_pkg::REQ_TICK, 15, 127, 0);
		send_request(padsr_pkg::REQ_NOTE_OFF, 15, 127, 0);
		repeat (4) send_request(padsr_pkg::REQ_TICK, 15, 127, 0);
		// on and off before any tick: cancel
		send_request(padsr_pkg::REQ_NOTE_ON, 1, 5, 64);
		send_request(padsr_pkg::REQ_NOTE_OFF, 1, 5, 0);
		send_request(padsr_pkg::REQ_TICK, 1, 5, 0);
		// release cross-fade mid attack, then retrigger from release
		send_request(padsr_pkg::REQ_NOTE_ON, 1, 6, 1);
		send_request(padsr_pkg::REQ_TICK, 1, 6, 0);
		send_request(padsr_pkg::REQ_NOTE_OFF, 1, 6, 0);
		send_request(padsr_pkg::REQ_TICK, 1, 6, 0);
		send_request(padsr_pkg::REQ_NOTE_ON, 1, 6, 100);
		send_request(padsr_pkg::REQ_TICK, 1, 6, 0);
		send_request(padsr_pkg::REQ_PANIC, 1, 6, 0);
		send_request(padsr_pkg::REQ_TICK, 1, 6, 0);

		// Random: four envelope settings, extremes among them; idling changes by thirds.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: load_envelope(0, 1, 0, 65535, 0);
				1: load_envelope(1048575, 1048575, 1048575, 0, 32768);
				2: load_envelope(5, 40, 7, 20000, 30000);
				default: load_envelope(3, 2, 4, 32768, 65535);
			endcase
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				if (sent_items < RANDOM_ITEMS / 3) begin
					send_idle_pct = 10;
					recv_stall_pct = 61;
				end else if (sent_items < 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 61;
					recv_stall_pct = 10;
				end else begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				random_request();
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("polyphonic_adsr_envelope_tb passed");
		else
			$display("polyphonic_adsr_envelope_tb failed");
		$finish;
	end

endmodule

// ----- polyphonic_adsr_envelope.f -----
src/padsr_pkg.sv
src/padsr_ram.sv
src/polyphonic_adsr_envelope.sv
tb/padsr_checker.sv
tb/polyphonic_adsr_envelope_tb.sv
